// ===== src/sha_pkg.sv =====
// shared types, constants and round functions for the sha-256 hash engine
// used by sha_core and sha256_hash_engine; no dependencies
`default_nettype none

package sha_pkg;

    localparam int WORD_W  = 32;
    localparam int TOTAL_W = 61;
    localparam int ROUNDS  = 64;
    localparam int ROUND_W = $clog2(ROUNDS);

    typedef logic [0:7][WORD_W-1:0] t_hash;

    // initial hash value, word 0 first
    localparam t_hash H_INIT = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WORD_W-1:0] PAD_MARK = 32'h80000000;

    // control from the sequencer to the round unit
    typedef struct packed {
        logic              push;   // shift a word into the block window
        logic              start;  // with push: begin compressing the block
        logic              init;   // reload the initial hash value
        logic [WORD_W-1:0] word;
    } t_core_ctl;

    // status back from the round unit
    typedef struct packed {
        logic busy;
    } t_core_sts;

    function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    // round constants
    function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] r);
        case (r)
            6'd0:  round_k = 32'h428a2f98;
            6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;
            6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;
            6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;
            6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;
            6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;
            6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;
            6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;
            6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;
            6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;
            6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;
            6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;
            6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;
            6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;
            6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;
            6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;
            6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;
            6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;
            6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;
            6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;
            6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;
            6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;
            6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;
            6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;
            6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;
            6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;
            6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;
            6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;
            6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;
            6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;
            6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;
            6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;
            default: round_k = 32'hc67178f2;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== src/sha_stream_if.sv =====
// valid/ready channels for message words in and digest words out
// no dependencies
`default_nettype none

interface sha_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        end_of_message;

    modport source (output valid, message_word, valid_bytes, end_of_message, input ready);
    modport sink   (input valid, message_word, valid_bytes, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

// ===== src/sha_core.sv =====
// sha-256 round unit: 16-word schedule window, working variables, hash state
// depends on sha_pkg
`default_nettype none

module sha_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sha_pkg::t_core_ctl i_ctl,
    output sha_pkg::t_core_sts     o_sts,
    output sha_pkg::t_hash         o_hash
);

    typedef enum logic [2:0] {
        CORE_IDLE  = 3'b001,
        CORE_ROUND = 3'b010,
        CORE_SUM   = 3'b100
    } t_core_state;

    t_core_state                     r_state, n_state;
    logic [sha_pkg::ROUND_W-1:0]     r_round;
    sha_pkg::t_hash                  r_h;
    logic [0:7][sha_pkg::WORD_W-1:0] r_v, n_v;
    logic [0:15][sha_pkg::WORD_W-1:0] r_w;

    logic [sha_pkg::WORD_W-1:0] w_t1, w_t2, w_ch, w_maj, w_sched;

    // one round of compression and the next schedule word
    always_comb begin
        w_ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        w_maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        w_t1    = r_v[7] + sha_pkg::big_sigma1(r_v[4]) + w_ch
                + sha_pkg::round_k(r_round) + r_w[0];
        w_t2    = sha_pkg::big_sigma0(r_v[0]) + w_maj;
        w_sched = sha_pkg::small_sigma1(r_w[14]) + r_w[9]
                + sha_pkg::small_sigma0(r_w[1]) + r_w[0];
        n_v     = {w_t1 + w_t2, r_v[0], r_v[1], r_v[2], r_v[3] + w_t1, r_v[4], r_v[5], r_v[6]};
    end

    // state sequence
    always_comb begin
        n_state = r_state;
        case (r_state)
            CORE_IDLE: begin
                if (i_ctl.push && i_ctl.start) begin
                    n_state = CORE_ROUND;
                end
            end
            CORE_ROUND: begin
                if (r_round == sha_pkg::ROUND_W'(sha_pkg::ROUNDS - 1)) begin
                    n_state = CORE_SUM;
                end
            end
            CORE_SUM: begin
                n_state = CORE_IDLE;
            end
            default: begin
                n_state = CORE_IDLE;
            end
        endcase
    end

    // control state and hash value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CORE_IDLE;
            r_round <= '0;
            r_h     <= sha_pkg::H_INIT;
        end else begin
            r_state <= n_state;
            if (r_state == CORE_ROUND) begin
                r_round <= r_round + 1'b1;
            end else begin
                r_round <= '0;
            end
            if (r_state == CORE_SUM) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end else if (r_state == CORE_IDLE && i_ctl.init) begin
                r_h <= sha_pkg::H_INIT;
            end
        end
    end

    // schedule window and working variables
    always_ff @(posedge i_clk) begin
        if (r_state == CORE_ROUND) begin
            r_w <= {r_w[1:15], w_sched};
            r_v <= n_v;
        end else if (r_state == CORE_IDLE && i_ctl.push) begin
            r_w <= {r_w[1:15], i_ctl.word};
            if (i_ctl.start) begin
                r_v <= r_h;
            end
        end
    end

    assign o_sts.busy = (r_state != CORE_IDLE);
    assign o_hash     = r_h;

endmodule

`default_nettype wire

// ===== src/sha256_hash_engine.sv =====
// sha-256 hash engine top level: message word intake, padding sequencer, digest output
// depends on sha_pkg, sha_stream_if and sha_core
//
// A message word is taken while the sequencer is idle and shifted into the block
// window of the round unit. The word that fills a 16-word block starts a
// compression (64 rounds at one per cycle through the single round unit, then
// the hash update); no word is taken until the sequencer has seen the round unit
// finish. On the final word the sequencer writes the padding and the 64-bit bit
// length one word per cycle, pausing while a compression runs, runs one or two
// compressions, and presents the eight digest words, one per cycle while the
// sink is ready. The byte count is cleared when the last padded block starts its
// compression, and the hash state returns to its initial value after the eighth
// digest word.
`default_nettype none

module sha256_hash_engine (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sha_in_if.sink    i_msg,
    sha_out_if.source o_digest
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PAD  = 4'b0010,
        ST_COMP = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    t_state                      r_state, n_state;
    logic [sha_pkg::TOTAL_W-1:0] r_byte_total, n_byte_total;
    logic [3:0]                  r_slot, n_slot;
    logic                        r_need80, n_need80;
    logic                        r_zero_blk, n_zero_blk;
    logic                        r_final, n_final;
    logic                        r_padding, n_padding;
    logic [2:0]                  r_idx, n_idx;

    sha_pkg::t_core_ctl w_ctl;
    sha_pkg::t_core_sts w_sts;
    sha_pkg::t_hash     w_hash;

    logic [3:0]                 w_pos;
    logic                       w_acc;
    logic [2:0]                 w_nb;
    logic [sha_pkg::WORD_W-1:0] w_last_word, w_pad_word;
    logic [63:0]                w_bits;

    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts),
        .o_hash  (w_hash)
    );

    assign w_pos  = r_byte_total[5:2];
    assign w_acc  = i_msg.valid && i_msg.ready;
    assign w_bits = {r_byte_total, 3'b000};
    assign w_nb   = (i_msg.valid_bytes > 3'd4) ? 3'd4 : i_msg.valid_bytes;

    // final word with the end marker placed after its valid bytes
    always_comb begin
        case (w_nb)
            3'd0:    w_last_word = sha_pkg::PAD_MARK;
            3'd1:    w_last_word = {i_msg.message_word[31:24], 24'h800000};
            3'd2:    w_last_word = {i_msg.message_word[31:16], 16'h8000};
            3'd3:    w_last_word = {i_msg.message_word[31:8], 8'h80};
            default: w_last_word = i_msg.message_word;
        endcase
    end

    // padding word for the current slot
    always_comb begin
        if (r_need80) begin
            w_pad_word = sha_pkg::PAD_MARK;
        end else if (r_zero_blk) begin
            w_pad_word = '0;
        end else if (r_slot == 4'd14) begin
            w_pad_word = w_bits[63:32];
        end else if (r_slot == 4'd15) begin
            w_pad_word = w_bits[31:0];
        end else begin
            w_pad_word = '0;
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_byte_total = r_byte_total;
        n_slot       = r_slot;
        n_need80     = r_need80;
        n_zero_blk   = r_zero_blk;
        n_final      = r_final;
        n_padding    = r_padding;
        n_idx        = r_idx;
        w_ctl        = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    w_ctl.push = 1'b1;
                    w_ctl.start = (w_pos == 4'd15);
                    if (!i_msg.end_of_message) begin
                        w_ctl.word   = i_msg.message_word;
                        n_byte_total = r_byte_total + sha_pkg::TOTAL_W'(4);
                        n_padding    = 1'b0;
                        if (w_pos == 4'd15) begin
                            n_state = ST_COMP;
                        end
                    end else begin
                        w_ctl.word   = w_last_word;
                        n_byte_total = r_byte_total + sha_pkg::TOTAL_W'(w_nb);
                        n_need80     = (w_nb == 3'd4);
                        n_zero_blk   = (w_nb != 3'd4) && (w_pos == 4'd14);
                        n_slot       = w_pos + 4'd1;
                        n_padding    = 1'b1;
                        n_final      = 1'b0;
                        n_state      = (w_pos == 4'd15) ? ST_COMP : ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                w_ctl.push = 1'b1;
                w_ctl.word = w_pad_word;
                n_slot     = r_slot + 4'd1;
                if (r_need80) begin
                    n_need80   = 1'b0;
                    n_zero_blk = r_zero_blk || (r_slot >= 4'd14);
                end
                if (r_slot == 4'd15) begin
                    w_ctl.start = 1'b1;
                    n_state     = ST_COMP;
                    n_zero_blk  = 1'b0;
                    n_final     = !r_need80 && !r_zero_blk;
                    if (!r_need80 && !r_zero_blk) begin
                        n_byte_total = '0;
                    end
                end
            end
            ST_COMP: begin
                if (!w_sts.busy) begin
                    if (r_final) begin
                        n_state = ST_OUT;
                        n_idx   = '0;
                    end else if (r_padding) begin
                        n_state = ST_PAD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                if (o_digest.ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        w_ctl.init = 1'b1;
                        n_final    = 1'b0;
                        n_padding  = 1'b0;
                        n_state    = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_byte_total <= '0;
            r_slot       <= '0;
            r_need80     <= 1'b0;
            r_zero_blk   <= 1'b0;
            r_final      <= 1'b0;
            r_padding    <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_state      <= n_state;
            r_byte_total <= n_byte_total;
            r_slot       <= n_slot;
            r_need80     <= n_need80;
            r_zero_blk   <= n_zero_blk;
            r_final      <= n_final;
            r_padding    <= n_padding;
            r_idx        <= n_idx;
        end
    end

    // ports
    assign i_msg.ready          = (r_state == ST_IDLE);
    assign o_digest.valid       = (r_state == ST_OUT);
    assign o_digest.digest_word = w_hash[r_idx];
    assign o_digest.word_index  = r_idx;
    assign o_digest.last_word   = (r_idx == 3'd7);

`ifndef ASSERT_OFF
    // intake and digest output never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_msg.ready && o_digest.valid))
        else $error("intake open while digest words pending");

    // the round unit is never fed while it compresses
    a_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.push |-> !w_sts.busy)
        else $error("word pushed into busy round unit");

    // a word that completes a block starts a compression
    a_block_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !i_msg.end_of_message && w_pos == 4'd15) |=> w_sts.busy)
        else $error("full block did not start compression");

    // count is clear once the last digest word is taken
    a_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_digest.valid && o_digest.ready && o_digest.last_word) |=> (r_byte_total == '0))
        else $error("byte count not cleared after digest");
`endif

endmodule

`default_nettype wire

// ===== tb/sha_digest_scoreboard.sv =====
// digest predictor and scoreboard for the sha-256 hash engine testbench
// self-contained package; no dependency on the rtl package
`default_nettype none

package sha_tb_pkg;

    // sha-256 round additive constants, round 0 first
    localparam bit [0:63][31:0] ROUND_ADD = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // starting chaining value, word 0 first
    localparam bit [0:7][31:0] IV_WORDS = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam bit [31:0] PAD_BYTE = 32'h80;

    typedef struct packed {
        bit [31:0] digest_word;
        bit [2:0]  word_index;
        bit        last_word;
    } t_digest_entry;

    class digest_scoreboard;
        bit [31:0]     chain[8];
        bit [31:0]     blk[16];
        bit [60:0]     bytes_taken;
        t_digest_entry pending_digest[$];
        int            errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++) chain[i] = IV_WORDS[i];
            bytes_taken = '0;
        endfunction

        function bit [31:0] ror(bit [31:0] v, int n);
            return (v >> n) | (v << (32 - n));
        endfunction

        // one 64-round compression of blk into the chaining value
        function void compress_block();
            bit [31:0] w[64];
            bit [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
            for (int r = 0; r < 16; r++) w[r] = blk[r];
            for (int r = 16; r < 64; r++) begin
                s0 = ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3);
                s1 = ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10);
                w[r] = w[r-16] + s0 + w[r-7] + s1;
            end
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
            e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
            for (int r = 0; r < 64; r++) begin
                t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
                     + ROUND_ADD[r] + w[r];
                t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
                h = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
            chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
        endfunction

        // take one accepted message word; the final word queues eight digest words
        function void absorb_word(bit [31:0] word, bit [2:0] nbytes, bit eom);
            int unsigned   pos, nxt, n;
            bit [31:0]     keep;
            bit [63:0]     bitlen;
            t_digest_entry ent;
            pos = bytes_taken[5:2];
            if (!eom) begin
                // short count on a non-final word still means four bytes
                blk[pos] = word;
                bytes_taken += 61'd4;
                if (pos == 15) compress_block();
                return;
            end
            n = (nbytes > 3'd4) ? 4 : nbytes;
            bytes_taken += 61'(n);
            if (n < 4) begin
                keep = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
                blk[pos] = (word & keep) | (PAD_BYTE << (24 - 8 * n));
                nxt = pos + 1;
            end else begin
                blk[pos] = word;
                nxt = pos + 1;
                if (nxt == 16) begin
                    compress_block();
                    nxt = 0;
                end
                blk[nxt] = PAD_BYTE << 24;
                nxt++;
            end
            // no room for the length: close this block and open another
            if (nxt > 14) begin
                for (int i = nxt; i < 16; i++) blk[i] = '0;
                compress_block();
                nxt = 0;
            end
            for (int i = nxt; i < 14; i++) blk[i] = '0;
            bitlen = {bytes_taken, 3'b000};
            blk[14] = bitlen[63:32];
            blk[15] = bitlen[31:0];
            compress_block();
            for (int i = 0; i < 8; i++) begin
                ent.digest_word = chain[i];
                ent.word_index  = i[2:0];
                ent.last_word   = (i == 7);
                pending_digest.push_back(ent);
            end
            restart();
        endfunction

        task report(string what);
            errors++;
            $display("mismatch: %s", what);
        endtask

        // compare one accepted digest word with the oldest expected one
        task check_digest_word(bit [31:0] word, bit [2:0] idx, bit lw);
            t_digest_entry want;
            if (pending_digest.size() == 0) begin
                report($sformatf("unexpected digest word %h index %0d", word, idx));
                return;
            end
            want = pending_digest.pop_front();
            if (word != want.digest_word)
                report($sformatf("digest word %h, want %h (index %0d)",
                                 word, want.digest_word, want.word_index));
            if (idx != want.word_index)
                report($sformatf("word index %0d, want %0d", idx, want.word_index));
            if (lw != want.last_word)
                report($sformatf("last flag %0d, want %0d at index %0d",
                                 lw, want.last_word, want.word_index));
        endtask
    endclass

endpackage

`default_nettype wire

// ===== tb/tb_sha256_hash_engine.sv =====
// testbench for sha256_hash_engine: directed and random messages against a digest predictor
// depends on sha_stream_if, sha256_hash_engine and sha_tb_pkg
`default_nettype none

module tb_sha256_hash_engine;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 250;

    logic i_clk;
    logic i_rst_n;
    int   cycle_count;
    bit   calm;
    bit   gappy;
    int   words_sent;

    sha_tb_pkg::digest_scoreboard sb;

    sha_in_if  msg_if ();
    sha_out_if dig_if ();

    sha256_hash_engine uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_msg    (msg_if),
        .o_digest (dig_if)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // monitor: both channels in one process so the order is fixed
    always @(posedge i_clk) begin
        if (i_rst_n && msg_if.valid && msg_if.ready)
            sb.absorb_word(msg_if.message_word, msg_if.valid_bytes, msg_if.end_of_message);
        if (i_rst_n && dig_if.valid && dig_if.ready)
            sb.check_digest_word(dig_if.digest_word, dig_if.word_index, dig_if.last_word);
    end

    // digest sink: ready in random bursts, steady at the end
    initial begin
        int  left;
        bit  level;
        left  = 0;
        level = 1'b1;
        dig_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (calm) begin
                dig_if.ready <= 1'b1;
            end else begin
                if (left == 0) begin
                    level = ($urandom_range(0, 2) != 0);
                    left  = level ? $urandom_range(1, 40) : $urandom_range(1, 16);
                end
                left--;
                dig_if.ready <= level;
            end
        end
    end

    // send one word and wait until it is taken
    task send_word(input bit [31:0] word, input bit [2:0] nbytes, input bit eom);
        if (gappy && !calm && $urandom_range(0, 3) == 0) begin
            msg_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        msg_if.valid          <= 1'b1;
        msg_if.message_word   <= word;
        msg_if.valid_bytes    <= nbytes;
        msg_if.end_of_message <= eom;
        do @(posedge i_clk); while (!msg_if.ready);
        words_sent++;
    endtask

    // hold off the sender until every queued digest word has come out
    task wait_drained();
        msg_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_digest.size() != 0);
    endtask

    function bit [31:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // random message of nwords words, mostly full counts on non-final words
    task send_message(input int nwords);
        bit [2:0] nb;
        for (int k = 0; k < nwords - 1; k++) begin
            nb = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
            send_word(rand_word(), nb, 1'b0);
        end
        nb = ($urandom_range(0, 3) == 0) ? 3'd4 : 3'($urandom_range(0, 7));
        send_word(rand_word(), nb, 1'b1);
    endtask

    // message length, biased toward the block-boundary padding cases
    function int pick_length();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(1, 8);
            4, 5, 6:    return 16 * $urandom_range(0, 1) + $urandom_range(14, 17);
            7, 8:       return $urandom_range(1, 40);
            default:    return $urandom_range(40, 64);
        endcase
    endfunction

    initial begin
        int len;
        sb         = new();
        calm       = 1'b0;
        gappy      = 1'b1;
        words_sent = 0;
        i_rst_n               <= 1'b0;
        msg_if.valid          <= 1'b0;
        msg_if.message_word   <= '0;
        msg_if.valid_bytes    <= '0;
        msg_if.end_of_message <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty message, each final count, oversized counts, junk low bytes
        send_word(32'h0000_0000, 3'd0, 1'b1);
        send_word(32'hffff_ffff, 3'd1, 1'b1);
        send_word(32'h1234_5678, 3'd2, 1'b1);
        send_word(32'h6162_63ff, 3'd3, 1'b1);
        send_word(32'h0000_0000, 3'd4, 1'b1);
        send_word(32'hffff_ffff, 3'd7, 1'b1);
        send_word(32'habcd_ef01, 3'd5, 1'b1);
        // short non-final counts, final word leaves no room for the length
        for (int k = 0; k < 13; k++)
            send_word((k % 2) ? 32'hffff_ffff : 32'h0000_0000, 3'(k % 8), 1'b0);
        send_word(32'h8000_0001, 3'd4, 1'b1);
        wait_drained();

        // random messages
        while (words_sent < RANDOM_WORDS) begin
            if (words_sent > RANDOM_WORDS - 40) calm = 1'b1;
            gappy = ($urandom_range(0, 2) != 0);
            len   = pick_length();
            send_message(len);
            if ($urandom_range(0, 4) == 0) wait_drained();
        end

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_digest.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
src/sha_pkg.sv
src/sha_stream_if.sv
src/sha_core.sv
src/sha256_hash_engine.sv
tb/sha_digest_scoreboard.sv
tb/tb_sha256_hash_engine.sv
